// ===== design/apsfc_pkg.sv =====
// shared types, codes and constants of the amplifier power sequencer with fan control
package apsfc_pkg;

   localparam int DutyBits    = 8;
   localparam int ElapsedBits = 22;
   localparam int WaitBits    = 16;

   localparam logic [ElapsedBits-1:0] ElapsedMax = '1;

   // power states, as seen on the power_state field
   typedef enum logic [1:0] {
      PWR_OFF  = 2'd0,
      PWR_MUTE = 2'd1,
      PWR_ON   = 2'd2
   } power_state_type;

   // event codes of the action field
   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_LINK_UP   = 3'd1,
      ACT_LINK_DOWN = 3'd2,
      ACT_TITLE     = 3'd3,
      ACT_AUDIO     = 3'd4,
      ACT_TEMP      = 3'd5
   } action_type;

   // register indexes of the csr port
   localparam logic [2:0] REG_STANDBY_DELAY = 3'd0;
   localparam logic [2:0] REG_WAKE_DELAY    = 3'd1;
   localparam logic [2:0] REG_MUTE_DELAY    = 3'd2;
   localparam logic [2:0] REG_FAN_OFF_TEMP  = 3'd3;
   localparam logic [2:0] REG_FAN_FULL_TEMP = 3'd4;
   localparam logic [2:0] REG_FAN_MIN_DUTY  = 3'd5;
   localparam logic [2:0] REG_FAN_MAX_DUTY  = 3'd6;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_FAN,
      CTL_RESP
   } ctl_state_type;

   typedef enum logic [2:0] {
      FAN_IDLE,
      FAN_MUL,
      FAN_DIV,
      FAN_FIX,
      FAN_DONE
   } fan_state_type;

   typedef struct packed {
      logic signed [7:0]    off_temp;
      logic signed [7:0]    full_temp;
      logic [DutyBits-1:0]  min_duty;
      logic [DutyBits-1:0]  max_duty;
   } fan_cfg_type;

   typedef struct packed {
      logic                start;
      logic                amp_on;
      logic                fault;
      logic signed [11:0]  temperature;
   } fan_req_type;

   typedef struct packed {
      logic                done;
      logic [DutyBits-1:0] duty;
   } fan_rsp_type;

endpackage

// ===== design/apsfc_if.sv =====
// valid/ready channel interfaces: event words, result words and register writes
interface apsfc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [11:0] temperature;
   logic               sensor_fault;

   modport source (output valid, action, temperature, sensor_fault, input ready);
   modport sink   (input valid, action, temperature, sensor_fault, output ready);
endinterface

interface apsfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        standby_pin;
   logic        mute_pin;
   logic [1:0]  power_state;
   logic [7:0]  fan_duty;
   logic [15:0] settle_wait_ms;
   logic        last;

   modport source (output valid, standby_pin, mute_pin, power_state, fan_duty,
                   settle_wait_ms, last, input ready);
   modport sink   (input valid, standby_pin, mute_pin, power_state, fan_duty,
                   settle_wait_ms, last, output ready);
endinterface

interface apsfc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [21:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/apsfc_fan_map.sv =====
// fan duty map: clamp checks, then serial shift-add multiply and restoring divide
module apsfc_fan_map import apsfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fan_cfg_type cfg,
   input  fan_req_type req,
   output fan_rsp_type rsp
);

   fan_state_type       state_ff, state_in;
   logic [3:0]          count_ff, count_in;
   logic [15:0]         acc_ff, acc_in;
   logic [7:0]          mcand_ff, mcand_in;
   logic [7:0]          span_ff, span_in;
   logic [7:0]          rem_ff, rem_in;
   logic                neg_ff, neg_in;
   logic [DutyBits-1:0] duty_ff, duty_in;

   logic signed [7:0]   degree;
   logic signed [8:0]   span_s;
   logic [8:0]          rise;
   logic signed [8:0]   delta;
   logic [8:0]          delta_mag;
   logic                below, above, flat, to_zero, early;
   logic [8:0]          mul_sum;
   logic [8:0]          trial;
   logic                fits;
   logic [8:0]          trial_diff;
   logic [7:0]          quot;

   // floor of sixteenths is the arithmetic upper byte
   assign degree    = req.temperature[11:4];
   assign span_s    = {cfg.full_temp[7], cfg.full_temp} - {cfg.off_temp[7], cfg.off_temp};
   assign rise      = {degree[7], degree} - {cfg.off_temp[7], cfg.off_temp};
   assign delta     = {1'b0, cfg.max_duty} - {1'b0, cfg.min_duty};
   assign delta_mag = delta[8] ? (9'd0 - delta) : delta;
   assign below     = degree < cfg.off_temp;
   assign above     = degree > cfg.full_temp;
   assign flat      = span_s <= 9'sd0;
   assign to_zero   = !req.amp_on || req.fault || below;
   assign early     = to_zero || above || flat;

   // one multiplier bit per cycle
   assign mul_sum    = {1'b0, acc_ff[15:8]} + {1'b0, (acc_ff[0] ? mcand_ff : 8'd0)};
   // one quotient bit per cycle
   assign trial      = {rem_ff, acc_ff[15]};
   assign fits       = trial >= {1'b0, span_ff};
   assign trial_diff = trial - {1'b0, span_ff};
   assign quot       = acc_ff[7:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FAN_IDLE: begin
            if (req.start) state_in = early ? FAN_DONE : FAN_MUL;
         end
         FAN_MUL: begin
            if (count_ff == 4'd7) state_in = FAN_DIV;
         end
         FAN_DIV: begin
            if (count_ff == 4'd15) state_in = FAN_FIX;
         end
         FAN_FIX:  state_in = FAN_DONE;
         FAN_DONE: state_in = FAN_IDLE;
         default:  state_in = FAN_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      span_in  = span_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      duty_in  = duty_ff;
      case (state_ff)
         FAN_IDLE: begin
            if (req.start) begin
               duty_in  = to_zero ? '0 : cfg.max_duty;
               acc_in   = {8'd0, rise[7:0]};
               mcand_in = delta_mag[7:0];
               span_in  = span_s[7:0];
               neg_in   = delta[8];
               rem_in   = 8'd0;
               count_in = 4'd0;
            end
         end
         FAN_MUL: begin
            acc_in   = {mul_sum, acc_ff[7:1]};
            count_in = (count_ff == 4'd7) ? 4'd0 : count_ff + 4'd1;
         end
         FAN_DIV: begin
            rem_in   = fits ? trial_diff[7:0] : trial[7:0];
            acc_in   = {acc_ff[14:0], fits};
            count_in = count_ff + 4'd1;
         end
         FAN_FIX: begin
            // quotient is truncated toward zero, sign applied afterwards
            duty_in = cfg.min_duty + (neg_ff ? (8'd0 - quot) : quot);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.done = (state_ff == FAN_DONE);
      rsp.duty = duty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FAN_IDLE;
         count_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      span_ff  <= span_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      duty_ff  <= duty_in;
   end

endmodule

// ===== design/amp_power_sequencer_fan_ctl.sv =====
// amplifier power sequencer with idle timer, pin write sequencing and fan duty map
// timing: an event word shows its first result word in the cycle after acceptance; a temperature
//    word first passes the 8-step multiply and 16-step divide, which a clamped map skips
// flow: one word at a time; the next is taken once the last result word has gone
// reset: registers to their defaults, state mute, timer armed at zero, fan duty zero
module amp_power_sequencer_fan_ctl import apsfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   apsfc_req_if.sink   req,
   apsfc_rsp_if.source rsp,
   apsfc_csr_if.sink   csr
);

   // configuration registers
   logic [ElapsedBits-1:0] standby_delay_ff, standby_delay_in;
   logic [WaitBits-1:0]    wake_delay_ff, wake_delay_in;
   logic [WaitBits-1:0]    mute_delay_ff, mute_delay_in;
   fan_cfg_type            fan_cfg_ff, fan_cfg_in;

   // sequencer state
   ctl_state_type          ctl_state_ff, ctl_state_in;
   power_state_type        amp_state_ff, amp_state_in;
   logic [ElapsedBits-1:0] elapsed_ff, elapsed_in;
   logic                   armed_ff, armed_in;
   logic [DutyBits-1:0]    duty_now_ff, duty_now_in;

   // result word register, and the levels of a pending second word
   logic                   rsp_stby_ff, rsp_stby_in;
   logic                   rsp_mute_ff, rsp_mute_in;
   logic [WaitBits-1:0]    rsp_wait_ff, rsp_wait_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   next_stby_ff, next_stby_in;
   logic                   next_mute_ff, next_mute_in;

   logic                   req_ready;
   logic                   rsp_valid;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   csr_fire;
   action_type             action;

   // event decode results
   power_state_type        ev_target;
   logic [ElapsedBits-1:0] ev_elapsed;
   logic [ElapsedBits-1:0] tick_count;
   logic                   ev_armed;

   // pin write plan for the transition
   logic                   first_stby, first_mute, first_last;
   logic [WaitBits-1:0]    first_wait;
   logic                   second_stby, second_mute;

   fan_req_type            fan_req;
   fan_rsp_type            fan_rsp;

   assign req_fire = req.valid && req_ready;
   assign rsp_fire = rsp_valid && rsp.ready;
   assign csr_fire = csr.valid && csr.ready;
   assign action   = action_type'(req.action);

   apsfc_fan_map u_fan_map (
      .clock (clock),
      .reset (reset),
      .cfg   (fan_cfg_ff),
      .req   (fan_req),
      .rsp   (fan_rsp)
   );

   // register writes, taken whenever offered
   always_comb begin
      standby_delay_in = standby_delay_ff;
      wake_delay_in    = wake_delay_ff;
      mute_delay_in    = mute_delay_ff;
      fan_cfg_in       = fan_cfg_ff;
      if (csr_fire) begin
         case (csr.index)
            REG_STANDBY_DELAY: standby_delay_in       = csr.data;
            REG_WAKE_DELAY:    wake_delay_in          = csr.data[15:0];
            REG_MUTE_DELAY:    mute_delay_in          = csr.data[15:0];
            REG_FAN_OFF_TEMP:  fan_cfg_in.off_temp    = csr.data[7:0];
            REG_FAN_FULL_TEMP: fan_cfg_in.full_temp   = csr.data[7:0];
            REG_FAN_MIN_DUTY:  fan_cfg_in.min_duty    = csr.data[7:0];
            REG_FAN_MAX_DUTY:  fan_cfg_in.max_duty    = csr.data[7:0];
            default: ;
         endcase
      end
   end

   // idle timer: saturating count of ticks while armed
   assign tick_count = (elapsed_ff == ElapsedMax) ? elapsed_ff
                                                  : elapsed_ff + {{(ElapsedBits-1){1'b0}}, 1'b1};

   // event decode: target state and timer update
   always_comb begin
      ev_target  = amp_state_ff;
      ev_elapsed = elapsed_ff;
      ev_armed   = armed_ff;
      case (action)
         ACT_TICK: begin
            if (armed_ff) begin
               ev_elapsed = tick_count;
               if (tick_count > standby_delay_ff) begin
                  // step down one state; expiry while off changes nothing
                  if (amp_state_ff == PWR_ON) begin
                     ev_target  = PWR_MUTE;
                     ev_elapsed = '0;
                  end else if (amp_state_ff == PWR_MUTE) begin
                     ev_target  = PWR_OFF;
                     ev_elapsed = '0;
                     ev_armed   = 1'b0;
                  end
               end
            end
         end
         ACT_LINK_UP, ACT_LINK_DOWN: begin
            ev_target  = PWR_MUTE;
            ev_elapsed = '0;
            ev_armed   = 1'b1;
         end
         ACT_TITLE, ACT_AUDIO: begin
            ev_target  = PWR_ON;
            ev_elapsed = '0;
            ev_armed   = 1'b1;
         end
         default: ;   // temperature sample and unused codes keep the state
      endcase
   end

   // pin write plan: waking from off raises standby first, dropping from on
   // to off mutes first; both hold the first levels for the settle wait
   always_comb begin
      first_stby  = (ev_target != PWR_OFF);
      first_mute  = (ev_target == PWR_ON);
      first_wait  = '0;
      first_last  = 1'b1;
      second_stby = 1'b0;
      second_mute = 1'b0;
      if (ev_target != amp_state_ff) begin
         if (amp_state_ff == PWR_OFF) begin
            first_stby  = 1'b1;
            first_mute  = 1'b0;
            first_wait  = wake_delay_ff;
            first_last  = 1'b0;
            second_stby = 1'b1;
            second_mute = (ev_target == PWR_ON);
         end else if (ev_target == PWR_OFF && amp_state_ff == PWR_ON) begin
            first_stby  = 1'b1;
            first_mute  = 1'b0;
            first_wait  = mute_delay_ff;
            first_last  = 1'b0;
            second_stby = 1'b0;
            second_mute = 1'b0;
         end
      end
   end

   // sequencer next state
   always_comb begin
      ctl_state_in = ctl_state_ff;
      case (ctl_state_ff)
         CTL_IDLE: begin
            if (req_fire) ctl_state_in = (action == ACT_TEMP) ? CTL_FAN : CTL_RESP;
         end
         CTL_FAN: begin
            if (fan_rsp.done) ctl_state_in = CTL_RESP;
         end
         CTL_RESP: begin
            if (rsp_fire && rsp_last_ff) ctl_state_in = CTL_IDLE;
         end
         default: ctl_state_in = CTL_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready           = (ctl_state_ff == CTL_IDLE);
      rsp_valid           = (ctl_state_ff == CTL_RESP);
      fan_req.start       = (ctl_state_ff == CTL_IDLE) && req.valid && (action == ACT_TEMP);
      fan_req.amp_on      = (amp_state_ff == PWR_ON);
      fan_req.fault       = req.sensor_fault;
      fan_req.temperature = req.temperature;
   end

   // state and result word updates
   always_comb begin
      amp_state_in = amp_state_ff;
      elapsed_in   = elapsed_ff;
      armed_in     = armed_ff;
      duty_now_in  = duty_now_ff;
      rsp_stby_in  = rsp_stby_ff;
      rsp_mute_in  = rsp_mute_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_last_in  = rsp_last_ff;
      next_stby_in = next_stby_ff;
      next_mute_in = next_mute_ff;
      if (req_fire) begin
         amp_state_in = ev_target;
         elapsed_in   = ev_elapsed;
         armed_in     = ev_armed;
         rsp_stby_in  = first_stby;
         rsp_mute_in  = first_mute;
         rsp_wait_in  = first_wait;
         rsp_last_in  = first_last;
         next_stby_in = second_stby;
         next_mute_in = second_mute;
      end
      if (ctl_state_ff == CTL_FAN && fan_rsp.done) duty_now_in = fan_rsp.duty;
      // first word taken: the second one moves into the result register
      if (rsp_fire && !rsp_last_ff) begin
         rsp_stby_in = next_stby_ff;
         rsp_mute_in = next_mute_ff;
         rsp_wait_in = '0;
         rsp_last_in = 1'b1;
      end
   end

   assign req.ready          = req_ready;
   assign rsp.valid          = rsp_valid;
   assign rsp.standby_pin    = rsp_stby_ff;
   assign rsp.mute_pin       = rsp_mute_ff;
   assign rsp.power_state    = amp_state_ff;
   assign rsp.fan_duty       = duty_now_ff;
   assign rsp.settle_wait_ms = rsp_wait_ff;
   assign rsp.last           = rsp_last_ff;
   assign csr.ready          = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         standby_delay_ff     <= 22'd30000;
         wake_delay_ff        <= 16'd100;
         mute_delay_ff        <= 16'd50;
         fan_cfg_ff.off_temp  <= 8'sd40;
         fan_cfg_ff.full_temp <= 8'sd70;
         fan_cfg_ff.min_duty  <= 8'd80;
         fan_cfg_ff.max_duty  <= 8'd255;
         ctl_state_ff         <= CTL_IDLE;
         amp_state_ff         <= PWR_MUTE;
         elapsed_ff           <= '0;
         armed_ff             <= 1'b1;
         duty_now_ff          <= '0;
      end else begin
         standby_delay_ff     <= standby_delay_in;
         wake_delay_ff        <= wake_delay_in;
         mute_delay_ff        <= mute_delay_in;
         fan_cfg_ff           <= fan_cfg_in;
         ctl_state_ff         <= ctl_state_in;
         amp_state_ff         <= amp_state_in;
         elapsed_ff           <= elapsed_in;
         armed_ff             <= armed_in;
         duty_now_ff          <= duty_now_in;
      end
   end

   // result payload, qualified by the sequencer state
   always_ff @(posedge clock) begin
      rsp_stby_ff  <= rsp_stby_in;
      rsp_mute_ff  <= rsp_mute_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_last_ff  <= rsp_last_in;
      next_stby_ff <= next_stby_in;
      next_mute_ff <= next_mute_in;
   end

endmodule

// ===== test/amp_power_sequencer_fan_ctl_tb.sv =====
// testbench of the amplifier power sequencer: event words in, pin and fan words checked out
`timescale 1ns / 1ps

module amp_power_sequencer_fan_ctl_tb;
   import apsfc_pkg::*;

   // action codes the block ignores, still legal on the 3-bit field
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   // longest run of cycles with no word moving on any channel
   localparam int QuietLimit = 4000;

   typedef struct {
      logic [2:0]         action;
      logic signed [11:0] temperature;
      logic               fault;
   } event_word_type;

   typedef struct packed {
      logic        standby;
      logic        mute;
      logic [1:0]  state;
      logic [7:0]  duty;
      logic [15:0] settle_ms;
      logic        last;
   } pin_write_type;

   logic clock;
   logic reset = 1'b1;

   apsfc_req_if req_bus ();
   apsfc_rsp_if rsp_bus ();
   apsfc_csr_if csr_bus ();

   amp_power_sequencer_fan_ctl uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // event words waiting for the driver, pin writes waiting for the monitor
   event_word_type event_words_q[$];
   pin_write_type  pin_writes_q[$];
   event_word_type word_on_bus;
   logic           word_pending = 1'b0;

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int rsp_hold_cycles = 0;
   int fail_count      = 0;
   int quiet_cycles    = 0;

   // register copies, as the block should hold them
   logic [21:0]        standby_ms;
   logic [15:0]        wake_ms;
   logic [15:0]        mute_ms;
   logic signed [7:0]  fan_off_c;
   logic signed [7:0]  fan_full_c;
   logic [7:0]         fan_min_c;
   logic [7:0]         fan_max_c;

   // sequencer state copies
   power_state_type    amp_now     = PWR_MUTE;
   logic [21:0]        idle_ms     = '0;
   logic               timer_armed = 1'b1;
   logic [7:0]         duty_now    = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void push_pin_write(logic stby, logic mute, logic [15:0] settle,
                                          logic last);
      pin_write_type w;
      w.standby   = stby;
      w.mute      = mute;
      w.state     = amp_now;
      w.duty      = duty_now;
      w.settle_ms = settle;
      w.last      = last;
      pin_writes_q.push_back(w);
   endfunction

   // pin writes for a move to the target state; waking from off and dropping from on to off
   // take two writes with a settle time between them
   function automatic void move_power(power_state_type target);
      power_state_type from;
      from = amp_now;
      if (target == from) begin
         push_pin_write(from != PWR_OFF, from == PWR_ON, '0, 1'b1);
      end else begin
         amp_now = target;
         if (from == PWR_OFF) begin
            push_pin_write(1'b1, 1'b0, wake_ms, 1'b0);
            push_pin_write(1'b1, target == PWR_ON, '0, 1'b1);
         end else if (target == PWR_OFF && from == PWR_ON) begin
            push_pin_write(1'b1, 1'b0, mute_ms, 1'b0);
            push_pin_write(1'b0, 1'b0, '0, 1'b1);
         end else begin
            push_pin_write(target != PWR_OFF, target == PWR_ON, '0, 1'b1);
         end
      end
   endfunction

   // clamped linear map on whole degrees, quotient truncated toward zero
   function automatic logic [7:0] fan_duty_for(logic signed [11:0] raw, logic fault);
      int deg;
      int span;
      int num;
      if (amp_now != PWR_ON || fault) return '0;
      deg = int'(raw >>> 4);
      if (deg < int'(fan_off_c)) return '0;
      if (deg > int'(fan_full_c)) return fan_max_c;
      span = int'(fan_full_c) - int'(fan_off_c);
      if (span <= 0) return fan_max_c;
      num = (deg - int'(fan_off_c)) * (int'(fan_max_c) - int'(fan_min_c));
      return 8'(num / span + int'(fan_min_c));
   endfunction

   function automatic void advance_sequencer(event_word_type w);
      power_state_type target;
      target = amp_now;
      case (w.action)
         ACT_TICK: begin
            if (timer_armed) begin
               if (idle_ms != ElapsedMax) idle_ms++;
               // expiry steps down one state; off has nowhere to go
               if (idle_ms > standby_ms && amp_now != PWR_OFF) begin
                  idle_ms = '0;
                  if (amp_now == PWR_ON) begin
                     target = PWR_MUTE;
                  end else begin
                     target      = PWR_OFF;
                     timer_armed = 1'b0;
                  end
               end
            end
         end
         ACT_LINK_UP, ACT_LINK_DOWN: begin
            idle_ms     = '0;
            timer_armed = 1'b1;
            target      = PWR_MUTE;
         end
         ACT_TITLE, ACT_AUDIO: begin
            idle_ms     = '0;
            timer_armed = 1'b1;
            target      = PWR_ON;
         end
         ACT_TEMP: duty_now = fan_duty_for(w.temperature, w.fault);
         default: ;
      endcase
      move_power(target);
   endfunction

   // ---------------------------------------------------------------- driver

   // one word on the bus at a time; payload holds until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         word_pending = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_sequencer(word_on_bus);
            word_pending = 1'b0;
         end
         if (!word_pending && event_words_q.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            word_on_bus = event_words_q.pop_front();
            word_pending = 1'b1;
            req_bus.action       <= word_on_bus.action;
            req_bus.temperature  <= word_on_bus.temperature;
            req_bus.sensor_fault <= word_on_bus.fault;
         end
         req_bus.valid <= word_pending;
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      pin_write_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pin_writes_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got state %0d duty %0d",
                        $time, rsp_bus.power_state, rsp_bus.fan_duty);
               fail_count++;
            end else begin
               want = pin_writes_q.pop_front();
               check_field("standby_pin", want.standby, rsp_bus.standby_pin);
               check_field("mute_pin", want.mute, rsp_bus.mute_pin);
               check_field("power_state", want.state, rsp_bus.power_state);
               check_field("fan_duty", want.duty, rsp_bus.fan_duty);
               check_field("settle_wait_ms", want.settle_ms, rsp_bus.settle_wait_ms);
               check_field("last", want.last, rsp_bus.last);
            end
         end
         // a long hold-off backs the block up against its input
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic write_reg(logic [2:0] idx, logic [21:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_STANDBY_DELAY: standby_ms = value;
         REG_WAKE_DELAY:    wake_ms    = value[15:0];
         REG_MUTE_DELAY:    mute_ms    = value[15:0];
         REG_FAN_OFF_TEMP:  fan_off_c  = value[7:0];
         REG_FAN_FULL_TEMP: fan_full_c = value[7:0];
         REG_FAN_MIN_DUTY:  fan_min_c  = value[7:0];
         REG_FAN_MAX_DUTY:  fan_max_c  = value[7:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [21:0] stby, logic [15:0] wake, logic [15:0] mute,
                                logic signed [7:0] off_t, logic signed [7:0] full_t,
                                logic [7:0] lo_duty, logic [7:0] hi_duty);
      write_reg(REG_STANDBY_DELAY, stby);
      write_reg(REG_WAKE_DELAY, {6'd0, wake});
      write_reg(REG_MUTE_DELAY, {6'd0, mute});
      write_reg(REG_FAN_OFF_TEMP, {14'd0, off_t});
      write_reg(REG_FAN_FULL_TEMP, {14'd0, full_t});
      write_reg(REG_FAN_MIN_DUTY, {14'd0, lo_duty});
      write_reg(REG_FAN_MAX_DUTY, {14'd0, hi_duty});
   endtask

   function automatic logic [15:0] random_wait();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // mostly short idle timeouts so the timer expires often
   task automatic random_settings();
      int          pick;
      int          off_d;
      int          full_d;
      logic [21:0] stby;
      pick = $urandom_range(99);
      if (pick < 80) stby = 22'($urandom_range(12, 1));
      else if (pick < 95) stby = 22'($urandom_range(200, 13));
      else stby = 22'd3600000;
      off_d = -55 + int'($urandom_range(180));
      pick  = $urandom_range(99);
      if (pick < 15) full_d = off_d;
      else if (pick < 85) full_d = off_d + int'($urandom_range(125 - off_d));
      else full_d = -55 + int'($urandom_range(180));
      load_settings(stby, random_wait(), random_wait(), 8'(off_d), 8'(full_d),
                    8'($urandom), 8'($urandom));
   endtask

   task automatic queue_word(logic [2:0] act, int temp, logic fault);
      event_word_type w;
      w.action      = act;
      w.temperature = 12'(temp);
      w.fault       = fault;
      event_words_q.push_back(w);
   endtask

   task automatic queue_random_word();
      int         pick;
      int         lo;
      int         hi;
      int         temp;
      logic [2:0] act;
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_TICK;
      else if (pick < 48) act = ACT_LINK_UP;
      else if (pick < 55) act = ACT_LINK_DOWN;
      else if (pick < 63) act = ACT_TITLE;
      else if (pick < 70) act = ACT_AUDIO;
      else if (pick < 96) act = ACT_TEMP;
      else if (pick < 98) act = ACT_SPARE_A;
      else act = ACT_SPARE_B;
      // readings aimed around the linear range, then anywhere in range, then any code
      pick = $urandom_range(99);
      if (pick < 60) begin
         lo = int'(fan_off_c) - 5;
         hi = int'(fan_full_c) + 5;
         if (hi < lo) begin
            lo = int'(fan_full_c) - 5;
            hi = int'(fan_off_c) + 5;
         end
         temp = (lo + int'($urandom_range(hi - lo))) * 16 + int'($urandom_range(15));
         if (temp > 2047) temp = 2047;
      end else if (pick < 85) begin
         temp = -880 + int'($urandom_range(2880));
      end else begin
         temp = int'($urandom_range(4095));
      end
      queue_word(act, temp, $urandom_range(99) < 10);
   endtask

   // sender pause: nothing more goes in until every pin write has come back
   task automatic wait_until_quiet(int settle);
      while (event_words_q.size() != 0 || word_pending || pin_writes_q.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count / 2) queue_random_word();
      wait_until_quiet(4);
      repeat (count - count / 2) queue_random_word();
      wait_until_quiet(4);
   endtask

   // ---------------------------------------------------------------- test sequence

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_TICK;
      req_bus.temperature  = '0;
      req_bus.sensor_fault = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_STANDBY_DELAY;
      csr_bus.data         = '0;
      standby_ms = 22'd30000;
      wake_ms    = 16'd100;
      mute_ms    = 16'd50;
      fan_off_c  = 8'sd40;
      fan_full_c = 8'sd70;
      fan_min_c  = 8'd80;
      fan_max_c  = 8'd255;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: widest fan range, short timeout, extreme settle times
      load_settings(22'd2, 16'hFFFF, 16'd0, -8'sd55, 8'sd125, 8'd0, 8'd255);
      queue_word(ACT_TEMP, 0, 1'b0);          // sample while muted gives zero duty
      queue_word(ACT_TITLE, 0, 1'b0);         // mute to on
      queue_word(ACT_TEMP, 2047, 1'b0);       // hottest code, above full
      queue_word(ACT_TEMP, -2048, 1'b0);      // coldest code, below off
      queue_word(ACT_TEMP, -880, 1'b0);       // exactly at the off point
      queue_word(ACT_TEMP, 2000, 1'b0);       // exactly at the full point
      queue_word(ACT_TEMP, 800, 1'b1);        // sensor fault
      queue_word(ACT_TEMP, -1, 1'b0);         // floors to minus one degree
      queue_word(ACT_LINK_UP, 0, 1'b0);       // on to mute
      repeat (3) queue_word(ACT_TICK, 0, 1'b0);   // expiry from mute to off
      queue_word(ACT_TICK, 0, 1'b0);          // timer disarmed in off
      queue_word(ACT_SPARE_A, 0, 1'b0);
      queue_word(ACT_SPARE_B, 0, 1'b0);
      queue_word(ACT_AUDIO, 0, 1'b0);         // off to on, two writes with wake wait
      repeat (3) queue_word(ACT_TICK, 0, 1'b0);   // expiry from on to mute
      repeat (3) queue_word(ACT_TICK, 0, 1'b0);   // and mute to off
      queue_word(ACT_LINK_DOWN, 0, 1'b0);     // off to mute, two writes
      wait_until_quiet(4);

      // timeout at the counter's top never expires; zero span gives max duty
      load_settings(22'h3FFFFF, 16'd0, 16'hFFFF, 8'sd30, 8'sd30, 8'd200, 8'd10);
      queue_word(ACT_TITLE, 0, 1'b0);
      queue_word(ACT_TEMP, 480, 1'b0);
      queue_word(ACT_TEMP, 464, 1'b0);
      repeat (2) queue_word(ACT_TICK, 0, 1'b0);
      wait_until_quiet(4);

      // inverted thresholds
      load_settings(22'd5, 16'd1, 16'd1, 8'sd100, 8'sd20, 8'd255, 8'd0);
      queue_word(ACT_TEMP, 800, 1'b0);
      queue_word(ACT_TEMP, 1760, 1'b0);
      wait_until_quiet(4);

      // sender idles now and then, receiver more than half the time
      send_idle_pct = 24;
      recv_idle_pct = 54;
      random_settings();
      rsp_hold_cycles = 400;
      repeat (30) queue_random_word();
      wait_until_quiet(4);
      random_phase(240);
      random_settings();
      random_phase(240);

      // the other way round, two phases at the register extremes
      send_idle_pct = 54;
      recv_idle_pct = 24;
      load_settings(22'd1, 16'hFFFF, 16'hFFFF, -8'sd55, -8'sd55, 8'd255, 8'd255);
      random_phase(240);
      load_settings(22'd3600000, 16'd0, 16'd0, 8'sd125, 8'sd125, 8'd0, 8'd0);
      random_phase(100);
      random_settings();
      random_phase(140);

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_settings();
      random_phase(240);
      random_settings();
      random_phase(240);

      wait_until_quiet(30);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
